// ----- sv/per_node_command_retry_tracker_macros.svh -----
// ----------------------------------------------------------------------------
// per_node_command_retry_tracker_macros
// Assertion macros used by the retry tracker controller.
// ----------------------------------------------------------------------------
`ifndef PER_NODE_COMMAND_RETRY_TRACKER_MACROS_SVH
`define PER_NODE_COMMAND_RETRY_TRACKER_MACROS_SVH

`ifndef NO_ASSERTIONS
// checked only while out of reset
`define PNCRT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define PNCRT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PNCRT_ASSERT(lbl, clk, rst_n, prop, msg)
`define PNCRT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- sv/pncrt_pkg.sv -----
// ----------------------------------------------------------------------------
// pncrt_pkg
// Types and constants of the per-node command retry tracker.
// ----------------------------------------------------------------------------
package pncrt_pkg;

    localparam int MAX_PAYLOAD = 248;
    localparam int RETRY_MAX   = 15;

    typedef enum logic [2:0] {
        ACT_ENQUEUE = 3'd0,
        ACT_POLL    = 3'd1,
        ACT_ACK     = 3'd2,
        ACT_NACK    = 3'd3,
        ACT_TIMEOUT = 3'd4,
        ACT_CLEAR   = 3'd5
    } t_action;

    typedef enum logic [3:0] {
        EV_QUEUED        = 4'd0,
        EV_TOO_LARGE     = 4'd1,
        EV_FULL          = 4'd2,
        EV_SEND          = 4'd3,
        EV_EMPTY         = 4'd4,
        EV_WAITING       = 4'd5,
        EV_DROP_TIMEOUT  = 4'd6,
        EV_ACKED         = 4'd7,
        EV_NACK_RETRY    = 4'd8,
        EV_DROP_NACK     = 4'd9,
        EV_IGNORED       = 4'd10,
        EV_TIMEOUT_RETRY = 4'd11,
        EV_CLEARED       = 4'd12
    } t_event;

    typedef enum logic {
        CFG_RETRY_LIMIT = 1'b0,
        CFG_ACK_TIMEOUT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_action     action;
        logic [7:0]  node_id;
        logic [7:0]  command_kind;
        logic [7:0]  payload_length;
        logic [7:0]  response_sequence;
        logic [7:0]  response_status;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        t_event      event_res;
        logic [7:0]  out_node_id;
        logic [7:0]  out_command_kind;
        logic [7:0]  out_sequence;
        logic [3:0]  head_retries;
        logic [2:0]  queue_count;
        logic [7:0]  echoed_status;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic rd_ctrl;
        logic rd_data;
        logic commit;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic node_ok;
    } t_dp_stat;

endpackage

// ----- sv/pncrt_dp.sv -----
// ----------------------------------------------------------------------------
// pncrt_dp
// Datapath: per-node control memory, entry and send-time memories, the
// update logic and the result register.
// ----------------------------------------------------------------------------
module pncrt_dp import pncrt_pkg::*; #(
    parameter int NODE_COUNT  = 256,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    input  t_in_item    i_in,
    output t_out_item   o_out,
    input  logic        i_cfg_we,
    input  t_cfg_idx    i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_DEPTH = NODE_COUNT * (2 ** PW);

    typedef struct packed {
        logic [PW-1:0] rp;
        logic [CW-1:0] cnt;
        logic [3:0]    retry;
        logic          await;
    } t_node_ctl;

    t_node_ctl   r_ctl_mem [NODE_COUNT];
    logic [15:0] r_ent_mem [ENTRY_DEPTH];
    logic [31:0] r_lst_mem [NODE_COUNT];
    logic [NODE_COUNT-1:0] r_node_vld;

    t_in_item    r_item;
    t_node_ctl   r_ctl_q;
    logic        r_ctl_vld;
    logic [15:0] r_ent_q;
    logic [31:0] r_lst_q;
    logic [7:0]  r_next_seq;
    logic [3:0]  r_retry_limit;
    logic [31:0] r_ack_timeout;
    t_out_item   r_out;

    logic [NW-1:0] node_idx;
    logic          node_ok_q;
    t_node_ctl     c;
    t_node_ctl     n_ctl;
    t_out_item     n_out;
    logic          ent_we;
    logic [PW-1:0] ent_slot;
    logic [15:0]   ent_wdata;
    logic          lst_we;
    logic          seq_inc;

    assign o_stat.node_ok = ({1'b0, i_in.node_id} < 9'(NODE_COUNT));
    assign node_idx  = r_item.node_id[NW-1:0];
    assign node_ok_q = ({1'b0, r_item.node_id} < 9'(NODE_COUNT));
    // a node never written reads as all zero
    assign c = r_ctl_vld ? r_ctl_q : '0;
    assign o_out = r_out;

    always_comb begin
        logic [CW:0]   slot_sum;
        logic [PW-1:0] rp_inc;
        logic [3:0]    retry_inc;
        logic          drop;
        logic [31:0]   elapsed;
        logic          timed_out;
        logic          have;
        logic [15:0]   entry;
        logic [7:0]    status;
        logic [CW+2:0] cnt_ext;
        t_event        ev;

        slot_sum = (CW+1)'(c.rp) + (CW+1)'(c.cnt);
        if (slot_sum >= (CW+1)'(QUEUE_DEPTH)) begin
            slot_sum = slot_sum - (CW+1)'(QUEUE_DEPTH);
        end
        rp_inc    = (c.rp == PW'(QUEUE_DEPTH - 1)) ? '0 : c.rp + 1'b1;
        retry_inc = (c.retry == 4'(RETRY_MAX)) ? c.retry : c.retry + 4'd1;
        drop      = (retry_inc >= r_retry_limit);
        elapsed   = r_item.now_ms - r_lst_q;
        timed_out = (elapsed > r_ack_timeout);
        have      = (c.cnt != '0);
        entry     = r_ent_q;
        status    = 8'd0;
        ev        = EV_IGNORED;
        n_ctl     = c;
        ent_we    = 1'b0;
        ent_slot  = slot_sum[PW-1:0];
        ent_wdata = {r_item.command_kind, r_next_seq};
        lst_we    = 1'b0;
        seq_inc   = 1'b0;

        unique case (r_item.action)
            ACT_ENQUEUE: begin
                if (r_item.payload_length > 8'(MAX_PAYLOAD)) begin
                    ev = EV_TOO_LARGE;
                end else if (c.cnt >= CW'(QUEUE_DEPTH)) begin
                    ev = EV_FULL;
                end else begin
                    ent_we  = 1'b1;
                    entry   = ent_wdata;
                    if (c.cnt == '0) begin
                        n_ctl.retry = 4'd0;
                        n_ctl.await = 1'b0;
                    end
                    n_ctl.cnt = c.cnt + 1'b1;
                    seq_inc   = 1'b1;
                    have      = 1'b1;
                    ev        = EV_QUEUED;
                end
            end
            ACT_POLL: begin
                if (!have) begin
                    ev = EV_EMPTY;
                end else if (c.await && !timed_out) begin
                    ev = EV_WAITING;
                end else if (c.await && drop) begin
                    n_ctl.rp    = rp_inc;
                    n_ctl.cnt   = c.cnt - 1'b1;
                    n_ctl.retry = 4'd0;
                    n_ctl.await = 1'b0;
                    ev          = EV_DROP_TIMEOUT;
                end else begin
                    if (c.await) begin
                        n_ctl.retry = retry_inc;
                    end
                    n_ctl.await = 1'b1;
                    lst_we      = 1'b1;
                    ev          = EV_SEND;
                end
            end
            ACT_ACK: begin
                if (have && entry[7:0] == r_item.response_sequence) begin
                    n_ctl.rp    = rp_inc;
                    n_ctl.cnt   = c.cnt - 1'b1;
                    n_ctl.retry = 4'd0;
                    n_ctl.await = 1'b0;
                    ev          = EV_ACKED;
                end
            end
            ACT_NACK, ACT_TIMEOUT: begin
                if ((r_item.action == ACT_NACK)
                        ? (have && entry[7:0] == r_item.response_sequence)
                        : (have && c.await && timed_out)) begin
                    if (r_item.action == ACT_NACK) begin
                        status = r_item.response_status;
                    end
                    if (drop) begin
                        n_ctl.rp    = rp_inc;
                        n_ctl.cnt   = c.cnt - 1'b1;
                        n_ctl.retry = 4'd0;
                        n_ctl.await = 1'b0;
                        ev = (r_item.action == ACT_NACK) ? EV_DROP_NACK : EV_DROP_TIMEOUT;
                    end else begin
                        n_ctl.retry = retry_inc;
                        n_ctl.await = 1'b0;
                        ev = (r_item.action == ACT_NACK) ? EV_NACK_RETRY : EV_TIMEOUT_RETRY;
                    end
                end
            end
            ACT_CLEAR: begin
                n_ctl = '0;
                have  = 1'b0;
                ev    = EV_CLEARED;
            end
            default: begin
                ev = EV_IGNORED;
            end
        endcase

        cnt_ext = (CW+3)'(n_ctl.cnt);
        n_out.event_res        = ev;
        n_out.out_node_id      = r_item.node_id;
        n_out.out_command_kind = have ? entry[15:8] : 8'd0;
        n_out.out_sequence     = have ? entry[7:0] : 8'd0;
        n_out.head_retries     = (n_ctl.cnt != '0) ? n_ctl.retry : 4'd0;
        n_out.queue_count      = cnt_ext[2:0];
        n_out.echoed_status    = status;

        if (!node_ok_q) begin
            n_out            = '0;
            n_out.event_res  = EV_IGNORED;
            n_out.out_node_id = r_item.node_id;
            ent_we           = 1'b0;
            lst_we           = 1'b0;
            seq_inc          = 1'b0;
        end
    end

    // memories and payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in;
        end
        if (i_cmd.rd_ctrl) begin
            r_ctl_q   <= r_ctl_mem[node_idx];
            r_ctl_vld <= r_node_vld[node_idx];
        end
        if (i_cmd.rd_data) begin
            r_ent_q <= r_ent_mem[{node_idx, c.rp}];
            r_lst_q <= r_lst_mem[node_idx];
        end
        if (i_cmd.commit && node_ok_q) begin
            r_ctl_mem[node_idx] <= n_ctl;
        end
        if (i_cmd.commit && ent_we) begin
            r_ent_mem[{node_idx, ent_slot}] <= ent_wdata;
        end
        if (i_cmd.commit && lst_we) begin
            r_lst_mem[node_idx] <= r_item.now_ms;
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    // control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_vld    <= '0;
            r_next_seq    <= 8'd1;
            r_retry_limit <= 4'd3;
            r_ack_timeout <= 32'd5000;
        end else begin
            if (i_cmd.commit && node_ok_q) begin
                r_node_vld[node_idx] <= 1'b1;
            end
            if (i_cmd.commit && seq_inc) begin
                r_next_seq <= r_next_seq + 8'd1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_RETRY_LIMIT: r_retry_limit <= i_cfg_data[3:0];
                    CFG_ACK_TIMEOUT: r_ack_timeout <= i_cfg_data;
                    default:         r_retry_limit <= r_retry_limit;
                endcase
            end
        end
    end

endmodule

// ----- sv/pncrt_ctrl.sv -----
// ----------------------------------------------------------------------------
// pncrt_ctrl
// Controller: sequences accept, control read, data read and update, and
// holds the result valid flag.
// ----------------------------------------------------------------------------
`include "per_node_command_retry_tracker_macros.svh"

module pncrt_ctrl import pncrt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CTRL,
        S_DATA,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_out_vld;
    logic   accept;

    // result slot is free now or empties at this edge
    assign o_in_stall  = !((r_state == S_IDLE) && (!r_out_vld || !i_out_stall));
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_vld;

    assign o_cmd.capture = accept;
    assign o_cmd.rd_ctrl = (r_state == S_CTRL);
    assign o_cmd.rd_data = (r_state == S_DATA);
    assign o_cmd.commit  = (r_state == S_EXEC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        // nodes out of range touch no memory
                        r_state <= i_stat.node_ok ? S_CTRL : S_EXEC;
                    end
                    if (r_out_vld && !i_out_stall) begin
                        r_out_vld <= 1'b0;
                    end
                end
                S_CTRL: begin
                    r_state <= S_DATA;
                    if (r_out_vld && !i_out_stall) begin
                        r_out_vld <= 1'b0;
                    end
                end
                S_DATA: begin
                    r_state <= S_EXEC;
                    if (r_out_vld && !i_out_stall) begin
                        r_out_vld <= 1'b0;
                    end
                end
                S_EXEC: begin
                    r_state   <= S_IDLE;
                    r_out_vld <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `PNCRT_ASSERT(a_exec_slot_free, i_clk, i_rst_n, (r_state == S_EXEC) |-> !(r_out_vld && i_out_stall), "result slot busy at update")
    `PNCRT_ASSERT(a_vld_from_exec, i_clk, i_rst_n, $rose(r_out_vld) |-> $past(r_state == S_EXEC), "result valid without update")
    `PNCRT_ASSERT(a_accept_leaves_idle, i_clk, i_rst_n, accept |=> (r_state != S_IDLE), "accepted beat not processed")
    `PNCRT_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> (r_state == S_IDLE) && !r_out_vld, "reset did not clear control")

endmodule

// ----- sv/per_node_command_retry_tracker.sv -----
// ----------------------------------------------------------------------------
// per_node_command_retry_tracker
// Per-node command queues with stop-and-wait retransmission of each head.
// ----------------------------------------------------------------------------
// One result beat per input beat. An item for a valid node passes from accept
// to result through accept, read of the node's control word, read of the
// head entry and last send time (addressed by the read pointer just fetched),
// then the update and result register load. A node id at or above NODE_COUNT
// goes from accept straight to the update. The next item is taken once the
// controller is back in idle after the update, provided the result register
// is free or being drained. Per-node control state resets at once through a
// valid bit per node; no clearing pass.
module per_node_command_retry_tracker import pncrt_pkg::*; #(
    parameter int NODE_COUNT  = 256,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  t_cfg_idx    i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    pncrt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    pncrt_dp #(
        .NODE_COUNT  (NODE_COUNT),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in        (i_in),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

// ----- tb/sv/pncrt_scoreboard.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pncrt_scoreboard
// Watches the command and result channels of the retry tracker, keeps its own
// copy of every node queue and compares each result beat as a whole.
// ----------------------------------------------------------------------------
module pncrt_scoreboard import pncrt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_item    i_in,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_item   i_out,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  t_cfg_idx    i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results_seen,
    output int          o_events_seen
);

    localparam int NODES = 256;
    localparam int DEPTH = 4;

    logic [3:0]  lim;
    logic [31:0] tmo;
    logic [7:0]  seq_ctr;
    logic [15:0] slots [NODES*DEPTH];
    logic [1:0]  rd_ptr [NODES];
    logic [2:0]  depth_used [NODES];
    logic [3:0]  retries [NODES];
    logic        in_flight [NODES];
    logic [31:0] sent_at [NODES];

    t_out_item   expected_q[$];
    int          fails;
    int          seen;
    logic [12:0] ev_mask;

    assign o_fail_count   = fails;
    assign o_pending      = expected_q.size();
    assign o_results_seen = seen;
    assign o_events_seen  = $countones(ev_mask);

    function automatic logic late(int n, logic [31:0] now);
        logic [31:0] d;
        d = now - sent_at[n];
        return d > tmo;
    endfunction

    // one failed attempt; returns 1 when the head must be dropped
    function automatic logic fail_attempt(int n);
        in_flight[n] = 1'b0;
        if (retries[n] < 4'd15) retries[n] = retries[n] + 4'd1;
        return retries[n] >= lim;
    endfunction

    function automatic void drop_head(int n);
        rd_ptr[n]     = rd_ptr[n] + 2'd1;
        depth_used[n] = depth_used[n] - 3'd1;
        retries[n]    = '0;
        in_flight[n]  = 1'b0;
    endfunction

    function automatic t_out_item track_command(t_in_item c);
        t_out_item r;
        int        n;
        logic      have;
        logic [15:0] ent;
        t_event    ev;
        logic [7:0] st;
        n    = c.node_id;
        have = 1'b0;
        ent  = '0;
        ev   = EV_IGNORED;
        st   = '0;
        if (depth_used[n] != 0) begin
            ent  = slots[n*DEPTH + rd_ptr[n]];
            have = 1'b1;
        end
        case (c.action)
            ACT_ENQUEUE: begin
                if (c.payload_length > MAX_PAYLOAD) ev = EV_TOO_LARGE;
                else if (depth_used[n] >= DEPTH) ev = EV_FULL;
                else begin
                    ent = {c.command_kind, seq_ctr};
                    slots[n*DEPTH + 2'(rd_ptr[n] + depth_used[n])] = ent;
                    if (depth_used[n] == 0) begin
                        retries[n]   = '0;
                        in_flight[n] = 1'b0;
                    end
                    depth_used[n] = depth_used[n] + 3'd1;
                    seq_ctr = seq_ctr + 8'd1;
                    have = 1'b1;
                    ev = EV_QUEUED;
                end
            end
            ACT_POLL: begin
                if (!have) ev = EV_EMPTY;
                else if (in_flight[n] && !late(n, c.now_ms)) ev = EV_WAITING;
                else if (in_flight[n] && fail_attempt(n)) begin
                    drop_head(n);
                    ev = EV_DROP_TIMEOUT;
                end else begin
                    sent_at[n]   = c.now_ms;
                    in_flight[n] = 1'b1;
                    ev = EV_SEND;
                end
            end
            ACT_ACK: begin
                if (have && ent[7:0] == c.response_sequence) begin
                    drop_head(n);
                    ev = EV_ACKED;
                end
            end
            ACT_NACK: begin
                if (have && ent[7:0] == c.response_sequence) begin
                    st = c.response_status;
                    if (fail_attempt(n)) begin
                        drop_head(n);
                        ev = EV_DROP_NACK;
                    end else ev = EV_NACK_RETRY;
                end
            end
            ACT_TIMEOUT: begin
                if (have && in_flight[n] && late(n, c.now_ms)) begin
                    if (fail_attempt(n)) begin
                        drop_head(n);
                        ev = EV_DROP_TIMEOUT;
                    end else ev = EV_TIMEOUT_RETRY;
                end
            end
            ACT_CLEAR: begin
                depth_used[n] = '0;
                rd_ptr[n]     = '0;
                retries[n]    = '0;
                in_flight[n]  = 1'b0;
                have = 1'b0;
                ev = EV_CLEARED;
            end
            default: ;
        endcase
        r.event_res        = ev;
        r.out_node_id      = c.node_id;
        r.out_command_kind = have ? ent[15:8] : 8'd0;
        r.out_sequence     = have ? ent[7:0] : 8'd0;
        r.head_retries     = depth_used[n] != 0 ? retries[n] : 4'd0;
        r.queue_count      = depth_used[n];
        r.echoed_status    = st;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item e;
        if (!i_rst_n) begin
            lim = 4'd3;
            tmo = 32'd5000;
            seq_ctr = 8'd1;
            for (int i = 0; i < NODES; i++) begin
                rd_ptr[i] = '0;
                depth_used[i] = '0;
                retries[i] = '0;
                in_flight[i] = 1'b0;
                sent_at[i] = '0;
            end
            expected_q.delete();
            fails = 0;
            seen = 0;
            ev_mask = '0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_RETRY_LIMIT) lim = i_cfg_data[3:0];
                else tmo = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                seen++;
                if (expected_q.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected result beat %p", i_out);
                end else begin
                    e = expected_q.pop_front();
                    ev_mask[i_out.event_res] = 1'b1;
                    if (i_out !== e) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch at %0t: expected %p got %p", $realtime, e, i_out);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) expected_q.push_back(track_command(i_in));
        end
    end

endmodule

// ----- tb/sv/per_node_command_retry_tracker_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_node_command_retry_tracker_test
// Drives directed and random command sequences with idle gaps and a long
// result hold-off into the retry tracker; the scoreboard does the checking.
// ----------------------------------------------------------------------------
module per_node_command_retry_tracker_test;
    import pncrt_pkg::*;

    localparam int WATCHDOG = 20000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in_item    in_beat;
    logic        out_valid;
    logic        out_stall;
    t_out_item   out_beat;
    logic        cfg_valid;
    logic        cfg_ready;
    t_cfg_idx    cfg_index;
    logic [31:0] cfg_data;
    int          fail_count;
    int          pending;
    int          results_seen;
    int          events_seen;
    int          idle_cycles;
    logic        hold_off;
    logic [31:0] clock_ms;
    logic [7:0]  hot_nodes [4];

    per_node_command_retry_tracker u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in(in_beat),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out(out_beat),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    pncrt_scoreboard u_scoreboard (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in(in_beat),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out(out_beat),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_results_seen(results_seen), .o_events_seen(events_seen)
    );

    always begin
        clk = 1'b1; #1;
        clk = 1'b0; #1;
    end

    function automatic int short_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver side: random stalls plus a hold-off window on request
    initial begin
        int g;
        out_stall = 1'b1;
        @(negedge clk);
        while (!rst_n) @(negedge clk);
        forever begin
            if (hold_off) begin
                out_stall <= 1'b1;
                repeat (300) @(negedge clk);
            end
            g = short_gap();
            if (g == 0) begin
                out_stall <= 1'b0;
                @(negedge clk);
            end else begin
                out_stall <= 1'b1;
                repeat (g) @(negedge clk);
                out_stall <= 1'b0;
                @(negedge clk);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("watchdog expired, %0d results outstanding", pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    // valid stays up after the accepted beat; the next call either replaces
    // the beat or drops valid at the same falling edge
    task automatic send_cmd(t_in_item c, logic gaps);
        int g;
        g = gaps ? short_gap() : 0;
        if (g != 0) begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        in_beat  <= c;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic issue(t_action a, logic [7:0] n, logic [7:0] k, logic [7:0] len,
                         logic [7:0] sq, logic [7:0] st, logic [31:0] now);
        t_in_item c;
        c.action = a; c.node_id = n; c.command_kind = k; c.payload_length = len;
        c.response_sequence = sq; c.response_status = st; c.now_ms = now;
        send_cmd(c, 1'b1);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mostly plausible traffic on a handful of busy nodes
    task automatic random_cmd();
        t_in_item c;
        logic [95:0] rnd;
        int p;
        rnd = {$urandom, $urandom, $urandom};
        c = rnd[$bits(t_in_item)-1:0];
        p = $urandom_range(0, 99);
        if (p < 85) c.node_id = hot_nodes[$urandom_range(0, 3)];
        p = $urandom_range(0, 99);
        if (p < 3) c.action = t_action'(3'($urandom_range(6, 7)));
        else if (p < 28) c.action = ACT_ENQUEUE;
        else if (p < 50) c.action = ACT_POLL;
        else if (p < 66) c.action = ACT_ACK;
        else if (p < 80) c.action = ACT_NACK;
        else if (p < 95) c.action = ACT_TIMEOUT;
        else c.action = ACT_CLEAR;
        if ($urandom_range(0, 9) < 8) c.payload_length = 8'($urandom_range(0, 248));
        // replies usually carry a recent sequence number
        if ($urandom_range(0, 9) < 7)
            c.response_sequence = u_scoreboard.seq_ctr - 8'($urandom_range(1, 6));
        p = $urandom_range(0, 9);
        if (p < 7) clock_ms = clock_ms + $urandom_range(0, 3000);
        else if (p < 9) clock_ms = clock_ms + $urandom_range(3000, 12000);
        else clock_ms = $urandom;
        c.now_ms = (p == 9 || $urandom_range(0, 19) == 0) ? $urandom : clock_ms;
        send_cmd(c, 1'b1);
    endtask

    initial begin
        rst_n = 1'b0; in_valid = 1'b0; in_beat = '0;
        cfg_valid = 1'b0; cfg_index = CFG_RETRY_LIMIT; cfg_data = '0;
        hold_off = 1'b0; clock_ms = 32'd0;
        hot_nodes = '{8'd0, 8'd255, 8'd7, 8'd128};
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // directed: fill and overflow, oversize, send, timeouts, nack drops
        issue(ACT_ENQUEUE, 8'd0, 8'hFF, 8'd248, 8'd0, 8'd0, 32'd0);
        issue(ACT_ENQUEUE, 8'd0, 8'h00, 8'd249, 8'd0, 8'd0, 32'd0);
        issue(ACT_ENQUEUE, 8'd0, 8'hA5, 8'd255, 8'd0, 8'd0, 32'd0);
        issue(ACT_ENQUEUE, 8'd0, 8'h5A, 8'd0, 8'd0, 8'd0, 32'd0);
        issue(ACT_ENQUEUE, 8'd0, 8'h01, 8'd1, 8'd0, 8'd0, 32'd0);
        issue(ACT_ENQUEUE, 8'd0, 8'h02, 8'd2, 8'd0, 8'd0, 32'd0);
        issue(ACT_ENQUEUE, 8'd0, 8'h03, 8'd3, 8'd0, 8'd0, 32'd0);
        issue(ACT_POLL, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0);
        issue(ACT_POLL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 32'hFFFF_F000);
        issue(ACT_POLL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 32'h0000_0100);
        issue(ACT_TIMEOUT, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 32'h0000_0100);
        issue(ACT_TIMEOUT, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 32'h0000_2000);
        issue(ACT_POLL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 32'h0000_3000);
        issue(ACT_NACK, 8'd0, 8'd0, 8'd0, 8'd9, 8'hFF, 32'd0);
        issue(ACT_NACK, 8'd0, 8'd0, 8'd0, 8'd1, 8'hFF, 32'd0);
        issue(ACT_NACK, 8'd0, 8'd0, 8'd0, 8'd1, 8'h80, 32'd0);
        issue(ACT_ACK, 8'd0, 8'd0, 8'd0, 8'd2, 8'd0, 32'd0);
        issue(ACT_ACK, 8'd0, 8'd0, 8'd0, 8'd2, 8'd0, 32'd0);
        issue(ACT_TIMEOUT, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 32'hFFFF_FFFF);
        issue(t_action'(3'd6), 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0);
        issue(t_action'(3'd7), 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0);
        issue(ACT_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0);
        issue(ACT_POLL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0);

        // zero limit and zero timeout: first failure drops
        write_reg(CFG_RETRY_LIMIT, 32'd0);
        write_reg(CFG_ACK_TIMEOUT, 32'd0);
        issue(ACT_ENQUEUE, 8'd9, 8'h11, 8'd10, 8'd0, 8'd0, 32'd0);
        issue(ACT_POLL, 8'd9, 8'd0, 8'd0, 8'd0, 8'd0, 32'd5);
        issue(ACT_TIMEOUT, 8'd9, 8'd0, 8'd0, 8'd0, 8'd0, 32'd6);

        // random phases over several register settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(CFG_RETRY_LIMIT, 32'd1); write_reg(CFG_ACK_TIMEOUT, 32'd4000); end
                1: begin write_reg(CFG_RETRY_LIMIT, 32'd15); write_reg(CFG_ACK_TIMEOUT, 32'd0); end
                2: begin write_reg(CFG_RETRY_LIMIT, 32'd3); write_reg(CFG_ACK_TIMEOUT, 32'hFFFF_FFFF); end
                3: begin write_reg(CFG_RETRY_LIMIT, 32'($urandom_range(1, 15)));
                         write_reg(CFG_ACK_TIMEOUT, 32'($urandom_range(0, 8000))); end
                4: begin write_reg(CFG_RETRY_LIMIT, 32'd2); write_reg(CFG_ACK_TIMEOUT, 32'd1500); end
                default: begin write_reg(CFG_RETRY_LIMIT, 32'd5); write_reg(CFG_ACK_TIMEOUT, 32'd5000); end
            endcase
            for (int i = 0; i < 4; i++) hot_nodes[i] = (i == 0 && ph[0]) ? 8'd255 : 8'($urandom);
            if (ph == 2) hold_off = 1'b1;
            for (int i = 0; i < 255; i++) begin
                random_cmd();
                if (ph == 2 && i == 5) hold_off = 1'b0;
            end
        end
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        $display("%0d commands checked over six register settings, %0d event kinds seen",
                 results_seen, events_seen);
        if (fail_count == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/pncrt_pkg.sv
sv/pncrt_dp.sv
sv/pncrt_ctrl.sv
sv/per_node_command_retry_tracker.sv
tb/sv/pncrt_scoreboard.sv
tb/sv/per_node_command_retry_tracker_test.sv
